FILE: src/byte_stream_ascii_dump_encoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the byte stream ASCII dump encoder
// Both macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_ASCII_DUMP_ENCODER_TOP_MACROS_SVH
`define BYTE_STREAM_ASCII_DUMP_ENCODER_TOP_MACROS_SVH

// Same-cycle implication.
`define BSADE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BSADE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bsade_pkg.sv
// ----------------------------------------------------------------------------
// bsade_pkg
// Types, constants and helper functions shared by the dump encoder modules.
// ----------------------------------------------------------------------------
package bsade_pkg;

    // Run counter
    localparam int RUN_DIGITS  = 10;
    localparam int BCD_W       = 4 * RUN_DIGITS;

    // Result cap per input transaction
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS);

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int ESC_WORD_W  = 64;
    localparam int ESC_BITS    = 256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESC_LOW      = 3'd0,
        CFG_ESC_MID_LOW  = 3'd1,
        CFG_ESC_MID_HIGH = 3'd2,
        CFG_ESC_HIGH     = 3'd3,
        CFG_BREAK_EOL    = 3'd4
    } t_cfg_reg;

    // Job queue
    localparam int Q_PTR_W = 2;
    localparam int Q_DEPTH = 1 << Q_PTR_W;

    // Characters
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_COMMA   = 8'h2c;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LBRACK  = 8'h5b;
    localparam logic [7:0] CH_BSLASH  = 8'h5c;
    localparam logic [7:0] CH_RBRACK  = 8'h5d;
    localparam logic [7:0] CH_N       = 8'h6e;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_TILDE   = 8'h7e;
    localparam logic [7:0] BYTE_FF    = 8'hff;
    localparam logic [7:0] HEX_ALPHA  = 8'h57;   // 'a' - 10

    // Character slots of one encoded byte, in emission order
    localparam int         ENC_SLOTS     = 8;
    localparam logic [2:0] SL_QUOTE_A    = 3'd0;  // closing quote (line break or hex)
    localparam logic [2:0] SL_NEWLINE    = 3'd1;
    localparam logic [2:0] SL_COMMA      = 3'd2;
    localparam logic [2:0] SL_OPEN_QUOTE = 3'd3;
    localparam logic [2:0] SL_BSLASH     = 3'd4;
    localparam logic [2:0] SL_CHAR       = 3'd5;  // plain char or escape letter
    localparam logic [2:0] SL_HEX_HI     = 3'd6;
    localparam logic [2:0] SL_HEX_LO     = 3'd7;

    // Flat slot layout of a job: " [x" digits "]", run byte, new byte, end quote
    localparam int RUN_SLOTS  = RUN_DIGITS + 4;
    localparam int DIG_BASE   = 3;
    localparam int RBRK_SLOT  = DIG_BASE + RUN_DIGITS;
    localparam int E0_BASE    = RUN_SLOTS;
    localparam int E1_BASE    = RUN_SLOTS + ENC_SLOTS;
    localparam int ENDQ_SLOT  = RUN_SLOTS + 2 * ENC_SLOTS;
    localparam int SLOTS      = ENDQ_SLOT + 1;

    typedef struct packed {
        logic [ENC_SLOTS-1:0] mask;
        logic [7:0]           data;
        logic [7:0]           ch;
    } t_enc_seg;

    typedef struct packed {
        logic in_quotes;
        logic prev_eol;
        logic nothing;
        logic last_nl;
    } t_txt_state;

    typedef struct packed {
        t_enc_seg   seg;
        t_txt_state st;
    } t_enc_res;

    typedef struct packed {
        logic [SLOTS-1:0] mask;
        logic [BCD_W-1:0] bcd;
        t_enc_seg         enc0;
        t_enc_seg         enc1;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return {4'h0, n} + ((n < 4'd10) ? CH_ZERO : HEX_ALPHA);
    endfunction

    // Encodes one byte into its slot mask and advances the text state.
    function automatic t_enc_res encode_byte(input logic [7:0] b, input logic esc_bit,
                                             input logic brk, input t_txt_state st_in);
        t_enc_res r;
        logic     eol;
        logic     esc;
        logic     prn;
        r.seg.mask = '0;
        r.seg.data = b;
        r.seg.ch   = b;
        r.st       = st_in;
        eol = (b == CH_NUL) || (b == CH_NL) || (b == CH_CR);
        esc = esc_bit || (b == CH_QUOTE) || (b == CH_BSLASH);
        prn = (b >= CH_SPACE) && (b <= CH_TILDE);

        if (st_in.prev_eol && !eol && brk) begin
            if (r.st.in_quotes) begin
                r.seg.mask[SL_QUOTE_A] = 1'b1;
            end
            r.st.in_quotes         = 1'b0;
            r.seg.mask[SL_NEWLINE] = 1'b1;
            r.st.nothing           = 1'b0;
            r.st.last_nl           = 1'b1;
        end

        if (prn || esc) begin
            if (!r.st.in_quotes) begin
                if (!r.st.nothing && !r.st.last_nl) begin
                    r.seg.mask[SL_COMMA] = 1'b1;
                end
                r.seg.mask[SL_OPEN_QUOTE] = 1'b1;
                r.st.in_quotes            = 1'b1;
            end
            r.seg.mask[SL_CHAR] = 1'b1;
            if (esc) begin
                r.seg.mask[SL_BSLASH] = 1'b1;
                unique case (b)
                    CH_NL:     r.seg.ch = CH_N;
                    CH_CR:     r.seg.ch = CH_R;
                    CH_TAB:    r.seg.ch = CH_T;
                    CH_QUOTE:  r.seg.ch = CH_QUOTE;
                    CH_BSLASH: r.seg.ch = CH_BSLASH;
                    default: begin
                        r.seg.ch              = CH_X;
                        r.seg.mask[SL_HEX_HI] = 1'b1;
                        r.seg.mask[SL_HEX_LO] = 1'b1;
                    end
                endcase
            end
        end else begin
            if (r.st.in_quotes) begin
                r.seg.mask[SL_QUOTE_A] = 1'b1;
                r.st.in_quotes         = 1'b0;
                r.st.nothing           = 1'b0;
            end
            if (!r.st.nothing) begin
                r.seg.mask[SL_COMMA] = 1'b1;
            end
            r.seg.mask[SL_HEX_HI] = 1'b1;
            r.seg.mask[SL_HEX_LO] = 1'b1;
        end
        r.st.nothing  = 1'b0;
        r.st.last_nl  = 1'b0;
        r.st.prev_eol = eol;
        return r;
    endfunction

    function automatic logic [7:0] enc_slot_char(input t_enc_seg s, input logic [2:0] k);
        logic [7:0] c;
        unique case (k)
            SL_QUOTE_A:    c = CH_QUOTE;
            SL_NEWLINE:    c = CH_NL;
            SL_COMMA:      c = CH_COMMA;
            SL_OPEN_QUOTE: c = CH_QUOTE;
            SL_BSLASH:     c = CH_BSLASH;
            SL_CHAR:       c = s.ch;
            SL_HEX_HI:     c = hex_char(s.data[7:4]);
            SL_HEX_LO:     c = hex_char(s.data[3:0]);
            default:       c = CH_QUOTE;
        endcase
        return c;
    endfunction

    // Saturating BCD increment: stops at all nines.
    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] r;
        logic             carry;
        logic             all9;
        logic [3:0]       d;
        r     = v;
        carry = 1'b1;
        all9  = 1'b1;
        for (int i = 0; i < RUN_DIGITS; i++) begin
            d = v[4*i +: 4];
            if (d != 4'd9) begin
                all9 = 1'b0;
            end
            if (carry) begin
                if (d >= 4'd9) begin
                    r[4*i +: 4] = 4'd0;
                end else begin
                    r[4*i +: 4] = d + 4'd1;
                    carry       = 1'b0;
                end
            end
        end
        return all9 ? v : r;
    endfunction

    // Digit i is printed when it is at or below the top nonzero digit.
    function automatic logic [RUN_DIGITS-1:0] bcd_dig_en(input logic [BCD_W-1:0] v);
        logic [RUN_DIGITS-1:0] en;
        logic                  any;
        any = 1'b0;
        for (int i = RUN_DIGITS - 1; i >= 0; i--) begin
            any   = any || (v[4*i +: 4] != 4'd0);
            en[i] = any || (i == 0);
        end
        return en;
    endfunction

endpackage

FILE: src/byte_stream_ascii_dump_encoder_top.sv
// ----------------------------------------------------------------------------
// byte_stream_ascii_dump_encoder_top
// Turns a byte stream into a readable text dump, one character per result.
//
// An input byte is taken in every cycle while the four-entry job queue has
// room; the front classifies it and queues a job holding every character it
// causes. The back emits one character per clock unless the output stalls; a
// byte yields none inside a 0x00/0xFF run, usually one to four characters, at
// most 28 when a run is cut by a different byte that also ends the stream. On a
// restart from an empty queue the back first loads the head job into its
// registers. last_char marks the final character of each input transaction.
// Escape set and line-break mode are for the user to write through the cfg
// port only while no transaction is pending; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "byte_stream_ascii_dump_encoder_top_macros.svh"

module byte_stream_ascii_dump_encoder_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsade_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bsade_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_stream_end,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [7:0]                        o_text_char,
    output logic                              o_last_char
);

    logic                 q_push;
    logic                 q_pop;
    bsade_pkg::t_job      q_in_job;
    bsade_pkg::t_job      q_head;
    bsade_pkg::t_q_status q_stat;

    bsade_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_stream_end (i_stream_end),
        .i_q_stat     (q_stat),
        .o_push       (q_push),
        .o_job        (q_in_job)
    );

    bsade_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    bsade_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    `BSADE_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "job pushed into full queue")
    `BSADE_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty, "job popped from empty queue")
    `BSADE_ASSERT_NOW(a_end_emits, i_in_valid && o_in_ready && i_stream_end, q_push, "stream end without job")
    `BSADE_ASSERT_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue empty after push")

endmodule

FILE: src/bsade_front.sv
// ----------------------------------------------------------------------------
// bsade_front
// Accepts input bytes, tracks run and quoting state, and turns each byte into
// a job: a slot mask of the characters to emit plus the data behind them.
// ----------------------------------------------------------------------------
module bsade_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bsade_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bsade_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_stream_end,
    input  bsade_pkg::t_q_status              i_q_stat,
    output logic                              o_push,
    output bsade_pkg::t_job                   o_job
);

    localparam logic [bsade_pkg::BCD_W-1:0] BCD_THREE = bsade_pkg::BCD_W'(3);

    // Configuration
    logic [bsade_pkg::ESC_BITS-1:0] r_esc, n_esc;
    logic                           r_brk, n_brk;

    // Stream state
    bsade_pkg::t_txt_state          r_st, n_st;
    logic [7:0]                     r_prev0, n_prev0;
    logic [7:0]                     r_prev1, n_prev1;
    logic [1:0]                     r_seen, n_seen;
    logic                           r_run, n_run;
    logic [bsade_pkg::BCD_W-1:0]    r_bcd, n_bcd;

    logic                           acc;
    logic                           same;
    logic                           start;
    logic                           close;
    logic                           do_enc1;
    logic                           endq;
    logic [bsade_pkg::BCD_W-1:0]    bcd_up;
    logic [bsade_pkg::BCD_W-1:0]    close_bcd;
    logic [bsade_pkg::RUN_DIGITS-1:0] dig_en;
    bsade_pkg::t_txt_state          st_close;
    bsade_pkg::t_txt_state          st_mid;
    bsade_pkg::t_txt_state          st_fin;
    bsade_pkg::t_enc_res            e0;
    bsade_pkg::t_enc_res            e1;
    logic [bsade_pkg::RUN_SLOTS-1:0] run_mask;

    assign o_in_ready = !i_q_stat.full;
    assign acc        = i_in_valid && !i_q_stat.full;

    // Classification
    always_comb begin
        same  = (i_data_byte == r_prev0);
        start = !r_run && r_seen[1] && same && (i_data_byte == r_prev1) &&
                ((i_data_byte == bsade_pkg::CH_NUL) || (i_data_byte == bsade_pkg::BYTE_FF));
        bcd_up = bsade_pkg::bcd_inc(r_bcd);
        close  = (r_run && (!same || i_stream_end)) || (start && i_stream_end);
        do_enc1 = r_run ? !same : !start;
        if (r_run) begin
            close_bcd = same ? bcd_up : r_bcd;
        end else begin
            close_bcd = BCD_THREE;
        end
        dig_en = bsade_pkg::bcd_dig_en(close_bcd);

        st_close = r_st;
        if (close) begin
            st_close.nothing = 1'b0;
            st_close.last_nl = 1'b0;
        end
        e0     = bsade_pkg::encode_byte(r_prev0, r_esc[r_prev0], r_brk, st_close);
        st_mid = close ? e0.st : r_st;
        e1     = bsade_pkg::encode_byte(i_data_byte, r_esc[i_data_byte], r_brk, st_mid);
        st_fin = do_enc1 ? e1.st : st_mid;
        endq   = i_stream_end && st_fin.in_quotes;

        // " [x", digits most significant first, "]"
        run_mask = '0;
        run_mask[2:0] = 3'b111;
        for (int k = 0; k < bsade_pkg::RUN_DIGITS; k++) begin
            run_mask[bsade_pkg::DIG_BASE + k] = dig_en[bsade_pkg::RUN_DIGITS - 1 - k];
        end
        run_mask[bsade_pkg::RBRK_SLOT] = 1'b1;
    end

    always_comb begin
        o_job.mask = '0;
        if (close) begin
            o_job.mask[bsade_pkg::RUN_SLOTS-1:0] = run_mask;
            o_job.mask[bsade_pkg::E0_BASE +: bsade_pkg::ENC_SLOTS] = e0.seg.mask;
        end
        if (do_enc1) begin
            o_job.mask[bsade_pkg::E1_BASE +: bsade_pkg::ENC_SLOTS] = e1.seg.mask;
        end
        o_job.mask[bsade_pkg::ENDQ_SLOT] = endq;
        o_job.bcd  = close_bcd;
        o_job.enc0 = e0.seg;
        o_job.enc1 = e1.seg;
        o_push     = acc && (|o_job.mask);
    end

    // Configuration writes
    always_comb begin
        n_esc = r_esc;
        n_brk = r_brk;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsade_pkg::CFG_ESC_LOW:
                    n_esc[0*bsade_pkg::ESC_WORD_W +: bsade_pkg::ESC_WORD_W] = i_cfg_data;
                bsade_pkg::CFG_ESC_MID_LOW:
                    n_esc[1*bsade_pkg::ESC_WORD_W +: bsade_pkg::ESC_WORD_W] = i_cfg_data;
                bsade_pkg::CFG_ESC_MID_HIGH:
                    n_esc[2*bsade_pkg::ESC_WORD_W +: bsade_pkg::ESC_WORD_W] = i_cfg_data;
                bsade_pkg::CFG_ESC_HIGH:
                    n_esc[3*bsade_pkg::ESC_WORD_W +: bsade_pkg::ESC_WORD_W] = i_cfg_data;
                bsade_pkg::CFG_BREAK_EOL:
                    n_brk = i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stream state update
    always_comb begin
        n_st    = r_st;
        n_prev0 = r_prev0;
        n_prev1 = r_prev1;
        n_seen  = r_seen;
        n_run   = r_run;
        n_bcd   = r_bcd;
        if (acc) begin
            if (i_stream_end) begin
                n_st    = '{in_quotes: 1'b0, prev_eol: 1'b0, nothing: 1'b1, last_nl: 1'b0};
                n_prev0 = '0;
                n_prev1 = '0;
                n_seen  = '0;
                n_run   = 1'b0;
                n_bcd   = '0;
            end else begin
                n_st    = st_fin;
                n_prev0 = i_data_byte;
                n_prev1 = r_prev0;
                n_seen  = r_seen[1] ? r_seen : r_seen + 2'd1;
                n_run   = r_run ? same : start;
                if (r_run) begin
                    n_bcd = same ? bcd_up : '0;
                end else begin
                    n_bcd = start ? BCD_THREE : '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= '0;
            r_brk   <= 1'b0;
            r_st    <= '{in_quotes: 1'b0, prev_eol: 1'b0, nothing: 1'b1, last_nl: 1'b0};
            r_prev0 <= '0;
            r_prev1 <= '0;
            r_seen  <= '0;
            r_run   <= 1'b0;
            r_bcd   <= '0;
        end else begin
            r_esc   <= n_esc;
            r_brk   <= n_brk;
            r_st    <= n_st;
            r_prev0 <= n_prev0;
            r_prev1 <= n_prev1;
            r_seen  <= n_seen;
            r_run   <= n_run;
            r_bcd   <= n_bcd;
        end
    end

endmodule

FILE: src/bsade_fifo.sv
// ----------------------------------------------------------------------------
// bsade_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module bsade_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  bsade_pkg::t_job      i_job,
    input  logic                 i_pop,
    output bsade_pkg::t_job      o_head,
    output bsade_pkg::t_q_status o_stat
);

    bsade_pkg::t_job                r_mem [bsade_pkg::Q_DEPTH];
    logic [bsade_pkg::Q_PTR_W-1:0]  r_wr, n_wr;
    logic [bsade_pkg::Q_PTR_W-1:0]  r_rd, n_rd;
    logic [bsade_pkg::Q_PTR_W:0]    r_cnt, n_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (bsade_pkg::Q_PTR_W+1)'(bsade_pkg::Q_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop  ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

FILE: src/bsade_back.sv
// ----------------------------------------------------------------------------
// bsade_back
// Walks the job's slot mask into an output register, one character per cycle
// unless output stalls. The next job is taken on the last slot or when idle.
// ----------------------------------------------------------------------------
module bsade_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bsade_pkg::t_q_status i_q_stat,
    input  bsade_pkg::t_job      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_text_char,
    output logic                 o_last_char
);

    logic [bsade_pkg::SLOTS-1:0] r_mask, n_mask;
    logic [bsade_pkg::BCD_W-1:0] r_bcd, n_bcd;
    bsade_pkg::t_enc_seg         r_enc0, n_enc0;
    bsade_pkg::t_enc_seg         r_enc1, n_enc1;
    logic [bsade_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic [7:0]                  r_out_char, n_out_char;
    logic                        r_out_last, n_out_last;

    logic [7:0]                  slot_ch [bsade_pkg::SLOTS];
    logic [bsade_pkg::SLOTS-1:0] pick;
    logic [bsade_pkg::SLOTS-1:0] rest;
    logic [7:0]                  ch;
    logic [3:0]                  dig;
    logic                        busy;
    logic                        adv;
    logic                        last;

    // Character behind every slot of the current job
    always_comb begin
        slot_ch[0] = bsade_pkg::CH_SPACE;
        slot_ch[1] = bsade_pkg::CH_LBRACK;
        slot_ch[2] = bsade_pkg::CH_X;
        dig = '0;
        for (int k = 0; k < bsade_pkg::RUN_DIGITS; k++) begin
            dig = r_bcd[4*(bsade_pkg::RUN_DIGITS - 1 - k) +: 4];
            slot_ch[bsade_pkg::DIG_BASE + k] =
                bsade_pkg::CH_ZERO + {4'h0, (dig > 4'd9) ? 4'd9 : dig};
        end
        slot_ch[bsade_pkg::RBRK_SLOT] = bsade_pkg::CH_RBRACK;
        for (int k = 0; k < bsade_pkg::ENC_SLOTS; k++) begin
            slot_ch[bsade_pkg::E0_BASE + k] = bsade_pkg::enc_slot_char(r_enc0, 3'(k));
            slot_ch[bsade_pkg::E1_BASE + k] = bsade_pkg::enc_slot_char(r_enc1, 3'(k));
        end
        slot_ch[bsade_pkg::ENDQ_SLOT] = bsade_pkg::CH_QUOTE;
    end

    // Lowest pending slot goes out next
    always_comb begin
        pick = r_mask & (~r_mask + bsade_pkg::SLOTS'(1));
        rest = r_mask & ~pick;
        ch   = '0;
        for (int i = 0; i < bsade_pkg::SLOTS; i++) begin
            ch = ch | (pick[i] ? slot_ch[i] : 8'h00);
        end
        busy  = |r_mask;
        adv   = busy && (!r_out_valid || i_out_ready);
        // cap on characters per transaction
        last  = (rest == '0) || (r_cnt == bsade_pkg::CNT_W'(bsade_pkg::MAX_RESULTS - 1));
        o_pop = !i_q_stat.empty && (!busy || (adv && last));
    end

    always_comb begin
        n_mask = r_mask;
        n_bcd  = r_bcd;
        n_enc0 = r_enc0;
        n_enc1 = r_enc1;
        n_cnt  = r_cnt;
        if (o_pop) begin
            n_mask = i_head.mask;
            n_bcd  = i_head.bcd;
            n_enc0 = i_head.enc0;
            n_enc1 = i_head.enc1;
            n_cnt  = '0;
        end else if (adv) begin
            n_mask = last ? '0 : rest;
            n_cnt  = r_cnt + 1'b1;
        end
        n_out_valid = adv ? 1'b1 : (r_out_valid && !i_out_ready);
        n_out_char  = adv ? ch   : r_out_char;
        n_out_last  = adv ? last : r_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask      <= n_mask;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd      <= n_bcd;
        r_enc0     <= n_enc0;
        r_enc1     <= n_enc1;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_text_char = r_out_char;
    assign o_last_char = r_out_last;

endmodule
